@@ src/sgdmf_pkg.sv @@
// Shared types, constants and fixed-point helpers for the latent-factor update engine.
package sgdmf_pkg;

  localparam int MAX_DIMS  = 16;
  localparam int VERTICES  = 1024;
  localparam int DIM_W     = $clog2(MAX_DIMS);
  localparam int VERT_W    = $clog2(VERTICES);
  localparam int ADDR_W    = VERT_W + DIM_W;
  localparam int Q_W       = 48;
  localparam int RATE_W    = 16;
  localparam int FRAC_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 48;
  localparam int STEP_W    = 48;
  localparam int REGW_W    = 32;
  localparam int DIMS_W    = 5;

  localparam logic signed [Q_W-1:0] Q_MAX  = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN  = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [Q_W-1:0] HALF_Q = 48'sd2147483648;

  localparam logic [STEP_W-1:0] STEP_RST = 48'd98516242;
  localparam logic [REGW_W-1:0] REGW_RST = 32'd4294967;
  localparam logic [DIMS_W-1:0] DIMS_RST = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP = 2'd0,
    CFG_REGW = 2'd1,
    CFG_DIMS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [REGW_W-1:0] regw;
    logic [DIMS_W-1:0] dims;
  } cfg_t;

  typedef struct packed {
    logic                     kind;
    logic [VERT_W-1:0]        tb;
    logic [VERT_W-1:0]        nb;
    logic signed [RATE_W-1:0] rating;
  } item_t;

  typedef struct packed {
    logic           start;
    logic [Q_W-1:0] a_mag;
    logic [Q_W-1:0] b_mag;
    logic           neg;
    logic           sh48;
  } mul_req_t;

  function automatic logic signed [Q_W-1:0] sat49(input logic signed [Q_W:0] v);
    logic signed [Q_W-1:0] r;
    if (v[Q_W] != v[Q_W-1]) r = v[Q_W] ? Q_MIN : Q_MAX;
    else r = v[Q_W-1:0];
    return r;
  endfunction

  function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] s;
    s = {a[Q_W-1], a} + {b[Q_W-1], b};
    return sat49(s);
  endfunction

  function automatic logic signed [Q_W-1:0] sat_sub(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] s;
    s = {a[Q_W-1], a} - {b[Q_W-1], b};
    return sat49(s);
  endfunction

  function automatic logic [Q_W-1:0] mag(input logic signed [Q_W-1:0] v);
    logic [Q_W-1:0] r;
    r = v[Q_W-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

@@ src/sgdmf_front.sv @@
// Front end: accepts items, normalizes vertex numbers and queues them for the back end.
module sgdmf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [9:0]                    in_target_vertex,
  input  logic [9:0]                    in_neighbor_vertex,
  input  logic signed [15:0]            in_rating,
  input  logic                          clearing,
  input  logic                          q_pop,
  output logic                          q_valid,
  output sgdmf_pkg::item_t              q_item
);

  sgdmf_pkg::item_t q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  sgdmf_pkg::item_t in_item;

  assign in_stall = (cnt_r == 2'd2) || clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  // vertex field width is log2 of the vertex count, so the wrap is a plain mask
  always_comb begin
    in_item.kind   = in_kind;
    in_item.tb     = in_target_vertex[sgdmf_pkg::VERT_W-1:0];
    in_item.nb     = in_neighbor_vertex[sgdmf_pkg::VERT_W-1:0];
    in_item.rating = in_rating;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = (q_pop && q_valid) ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= in_item;
  end

endmodule

@@ src/sgdmf_mul.sv @@
// Iterative 48x48 multiplier: four 24x24 partial products, then round and saturate.
module sgdmf_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sgdmf_pkg::mul_req_t              req,
  output logic                             done,
  output logic signed [sgdmf_pkg::Q_W-1:0] res
);

  localparam int HW = sgdmf_pkg::Q_W / 2;
  localparam int PW = 2 * sgdmf_pkg::Q_W;

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_RUN  = 3'b010,
    M_FIN  = 3'b100
  } mstate_t;

  mstate_t state_r, state_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic [sgdmf_pkg::Q_W-1:0] a_r, b_r;
  logic                    neg_r, sh48_r;
  logic [PW-1:0]           acc_r, acc_nxt;
  logic                    done_r;
  logic signed [sgdmf_pkg::Q_W-1:0] res_r, res_nxt;
  logic [HW-1:0]           pa, pb;
  logic [2*HW-1:0]         pp;
  logic [PW-1:0]           rnd, t, q;

  assign done = done_r;
  assign res  = res_r;

  always_comb begin
    pa = cnt_r[0] ? a_r[2*HW-1:HW] : a_r[HW-1:0];
    pb = cnt_r[1] ? b_r[2*HW-1:HW] : b_r[HW-1:0];
    pp = pa * pb;
    case ({1'b0, cnt_r[0]} + {1'b0, cnt_r[1]})
      2'd0:    acc_nxt = acc_r + {{HW*2{1'b0}}, pp};
      2'd1:    acc_nxt = acc_r + ({{HW*2{1'b0}}, pp} << HW);
      default: acc_nxt = acc_r + ({{HW*2{1'b0}}, pp} << (2*HW));
    endcase
  end

  // round to nearest, ties away from zero, on the magnitude
  always_comb begin
    rnd = sh48_r ? (PW'(1) << 47) : (PW'(1) << 31);
    t   = acc_r + rnd;
    q   = sh48_r ? (t >> 48) : (t >> 32);
    if (neg_r) begin
      if (q > PW'({1'b1, {(sgdmf_pkg::Q_W-1){1'b0}}})) res_nxt = sgdmf_pkg::Q_MIN;
      else res_nxt = ~q[sgdmf_pkg::Q_W-1:0] + 1'b1;
    end else begin
      if (q > PW'(sgdmf_pkg::Q_MAX)) res_nxt = sgdmf_pkg::Q_MAX;
      else res_nxt = q[sgdmf_pkg::Q_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      M_IDLE: begin
        cnt_nxt = 2'd0;
        if (req.start) state_nxt = M_RUN;
      end
      M_RUN: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) state_nxt = M_FIN;
      end
      M_FIN: state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      cnt_r   <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= (state_r == M_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == M_IDLE && req.start) begin
      a_r    <= req.a_mag;
      b_r    <= req.b_mag;
      neg_r  <= req.neg;
      sh48_r <= req.sh48;
      acc_r  <= '0;
    end else if (state_r == M_RUN) begin
      acc_r <= acc_nxt;
    end
    if (state_r == M_FIN) res_r <= res_nxt;
  end

endmodule

@@ src/sgdmf_back.sv @@
// Back end: element sequencer with latent and gradient memories and the result register.
module sgdmf_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sgdmf_pkg::cfg_t                  cfg,
  input  logic                             q_valid,
  input  sgdmf_pkg::item_t                 q_item,
  output logic                             q_pop,
  output logic                             clearing,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [47:0]               out_value,
  output logic [3:0]                       out_element_index,
  output logic                             out_last
);

  localparam int QW = sgdmf_pkg::Q_W;
  localparam int DW = sgdmf_pkg::DIM_W;
  localparam int AW = sgdmf_pkg::ADDR_W;
  localparam int DEPTH = sgdmf_pkg::VERTICES * sgdmf_pkg::MAX_DIMS;

  typedef enum logic [7:0] {
    S_CLR  = 8'b00000001,
    S_IDLE = 8'b00000010,
    S_RD   = 8'b00000100,
    S_LD   = 8'b00001000,
    S_M1   = 8'b00010000,
    S_M2   = 8'b00100000,
    S_ERR  = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [QW-1:0] latent_mem [DEPTH];
  logic signed [QW-1:0] grad_mem   [DEPTH];

  sgdmf_pkg::item_t     item_r;
  logic                 phase_r, phase_nxt;
  logic [DW-1:0]        j_r, j_nxt;
  logic [AW-1:0]        clr_r;
  logic signed [QW-1:0] dot_r, err_r, lat_new_r;
  logic signed [QW-1:0] lat_a_q, lat_b_q, grd_q;
  logic [DW-1:0]        last_j;
  logic [AW-1:0]        addr_t, addr_n;
  logic                 lat_we, grd_we;
  logic [AW-1:0]        lat_wa;
  logic signed [QW-1:0] lat_wd, grd_wd, diff_c, rq;
  logic                 is_last, out_take;

  sgdmf_pkg::mul_req_t  mreq;
  logic                 mdone;
  logic signed [QW-1:0] mres;

  logic                 out_valid_r;
  logic signed [QW-1:0] out_value_r;
  logic [DW-1:0]        out_idx_r;
  logic                 out_last_r;

  sgdmf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .done  (mdone),
    .res   (mres)
  );

  // dimension count clamped to 1..MAX_DIMS
  always_comb begin
    if (cfg.dims == '0) last_j = '0;
    else if (cfg.dims > sgdmf_pkg::DIMS_W'(sgdmf_pkg::MAX_DIMS)) last_j = '1;
    else last_j = DW'(cfg.dims - 1'b1);
  end

  assign addr_t   = {item_r.tb, j_r};
  assign addr_n   = {item_r.nb, j_r};
  assign is_last  = (j_r == last_j);
  assign clearing = (state_r == S_CLR);
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign out_take = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign diff_c   = sgdmf_pkg::sat_sub(grd_q, mres);
  assign rq       = {item_r.rating, {sgdmf_pkg::FRAC_W{1'b0}}};

  always_comb begin
    mreq.start = 1'b0;
    mreq.a_mag = sgdmf_pkg::mag(lat_a_q);
    mreq.b_mag = sgdmf_pkg::mag(lat_b_q);
    mreq.neg   = lat_a_q[QW-1] ^ lat_b_q[QW-1];
    mreq.sh48  = 1'b0;
    if (state_r == S_LD) begin
      mreq.start = 1'b1;
      if (item_r.kind) begin
        mreq.a_mag = QW'(cfg.regw);
        mreq.b_mag = sgdmf_pkg::mag(lat_a_q);
        mreq.neg   = lat_a_q[QW-1];
      end else if (phase_r) begin
        mreq.a_mag = sgdmf_pkg::mag(lat_b_q);
        mreq.b_mag = sgdmf_pkg::mag(err_r);
        mreq.neg   = lat_b_q[QW-1] ^ err_r[QW-1];
      end
    end else if (state_r == S_M1 && mdone && item_r.kind) begin
      mreq.start = 1'b1;
      mreq.a_mag = cfg.step;
      mreq.b_mag = sgdmf_pkg::mag(diff_c);
      mreq.neg   = diff_c[QW-1];
      mreq.sh48  = 1'b1;
    end
  end

  always_comb begin
    lat_we = 1'b0;
    lat_wa = addr_t;
    lat_wd = sgdmf_pkg::sat_add(lat_a_q, mres);
    grd_we = 1'b0;
    grd_wd = item_r.kind ? '0 : sgdmf_pkg::sat_add(grd_q, mres);
    if (state_r == S_CLR) begin
      lat_we = 1'b1;
      lat_wa = clr_r;
      lat_wd = sgdmf_pkg::HALF_Q;
      grd_we = 1'b1;
      grd_wd = '0;
    end else if (state_r == S_M2 && mdone) begin
      lat_we = 1'b1;
      grd_we = 1'b1;
    end else if (state_r == S_M1 && mdone && !item_r.kind && phase_r) begin
      grd_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (lat_we) latent_mem[lat_wa] <= lat_wd;
    lat_a_q <= latent_mem[addr_t];
    lat_b_q <= latent_mem[addr_n];
  end

  always_ff @(posedge clk) begin
    if (grd_we) grad_mem[lat_wa] <= grd_wd;
    grd_q <= grad_mem[addr_t];
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_CLR:  if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        j_nxt     = '0;
        phase_nxt = 1'b0;
        if (q_valid) state_nxt = S_RD;
      end
      S_RD:   state_nxt = S_LD;
      S_LD:   state_nxt = S_M1;
      S_M1: begin
        if (mdone) begin
          if (item_r.kind) begin
            state_nxt = S_M2;
          end else if (is_last) begin
            state_nxt = phase_r ? S_OUT : S_ERR;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_M2:   if (mdone) state_nxt = S_OUT;
      S_ERR: begin
        phase_nxt = 1'b1;
        j_nxt     = '0;
        state_nxt = S_RD;
      end
      S_OUT: begin
        if (out_take) begin
          if (!item_r.kind || is_last) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      j_r         <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      phase_r <= phase_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (out_take) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
      dot_r  <= '0;
    end
    if (state_r == S_M1 && mdone && !item_r.kind && !phase_r)
      dot_r <= sgdmf_pkg::sat_add(dot_r, mres);
    if (state_r == S_ERR) err_r <= sgdmf_pkg::sat_sub(rq, dot_r);
    if (state_r == S_M2 && mdone) lat_new_r <= lat_wd;
    if (out_take) begin
      out_value_r <= item_r.kind ? lat_new_r : err_r;
      out_idx_r   <= item_r.kind ? j_r : '0;
      out_last_r  <= item_r.kind ? is_last : 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value         = out_value_r;
  assign out_element_index = out_idx_r;
  assign out_last          = out_last_r;

endmodule

@@ src/sgd_matrix_factorization_update.sv @@
// Top level: configuration registers, front-end queue and back-end sequencer.
// Each element of a vertex item costs one memory read and two passes of the 4-step
// multiplier; an edge item reads each element twice, once per phase, with one pass each.
// Throughput: one item at a time in the back end.
// Reset: synchronous active-low; afterwards a clearing pass writes 0.5 to every latent
// element and zero to every gradient element, in_stall high meanwhile.
module sgd_matrix_factorization_update (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [9:0]          in_target_vertex,
  input  logic [9:0]          in_neighbor_vertex,
  input  logic signed [15:0]  in_rating,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  out_value,
  output logic [3:0]          out_element_index,
  output logic                out_last,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [47:0]         cfg_data
);

  sgdmf_pkg::cfg_t  cfg_r, cfg_nxt;
  sgdmf_pkg::item_t q_item;
  logic             q_valid, q_pop, clearing;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sgdmf_pkg::CFG_STEP: cfg_nxt.step = cfg_data[sgdmf_pkg::STEP_W-1:0];
        sgdmf_pkg::CFG_REGW: cfg_nxt.regw = cfg_data[sgdmf_pkg::REGW_W-1:0];
        sgdmf_pkg::CFG_DIMS: cfg_nxt.dims = cfg_data[sgdmf_pkg::DIMS_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step <= sgdmf_pkg::STEP_RST;
      cfg_r.regw <= sgdmf_pkg::REGW_RST;
      cfg_r.dims <= sgdmf_pkg::DIMS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sgdmf_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_target_vertex   (in_target_vertex),
    .in_neighbor_vertex (in_neighbor_vertex),
    .in_rating          (in_rating),
    .clearing           (clearing),
    .q_pop              (q_pop),
    .q_valid            (q_valid),
    .q_item             (q_item)
  );

  sgdmf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_element_index (out_element_index),
    .out_last          (out_last)
  );

endmodule

@@ src/sgdmf_checker.sv @@
// Port-level checks for the latent-factor update engine, bound to the top level.
module sgdmf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [47:0] out_value,
  input logic [3:0]         out_element_index,
  input logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_value) && $stable(out_element_index))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("items taken or results shown during clearing");

  a_not_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_element_index != 4'hf)
    else $error("final dimension not marked last");

endmodule

bind sgd_matrix_factorization_update sgdmf_checker u_sgdmf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_value         (out_value),
  .out_element_index (out_element_index),
  .out_last          (out_last)
);
